// ----- sv/texture_upload_command_filter_macros.svh -----
// assertion macros for the texture upload command filter
// expects i_clk and i_rst_n in the scope of each use
`ifndef TEXTURE_UPLOAD_COMMAND_FILTER_MACROS_SVH
`define TEXTURE_UPLOAD_COMMAND_FILTER_MACROS_SVH

// same-cycle implication, quiet during reset
`define TUF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define TUF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/tuf_pkg.sv -----
// shared types and constants of the texture upload command filter
// no dependencies
package tuf_pkg;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] command_size;
        logic [31:0] bytes_left;
        logic [31:0] command_number;
        logic [31:0] word_at_12;
        logic [63:0] dword_at_16;
        logic [31:0] word_at_24;
        logic [31:0] word_at_28;
        logic [31:0] word_at_40;
        logic [31:0] word_at_44;
        logic [31:0] word_at_68;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [31:0] new_base_mip;
        logic [31:0] new_mip_count;
        logic [31:0] deferred_texture;
        logic [31:0] deferred_mip;
        logic [63:0] advance_bytes;
    } t_res;

    // one table entry as stored in the ram
    typedef struct packed {
        logic [31:0] texture;
        logic [31:0] first_mip;
    } t_entry;

    typedef enum logic [2:0] {
        VERDICT_FORWARD   = 3'd0,
        VERDICT_REWRITTEN = 3'd1,
        VERDICT_DEFERRED  = 3'd2,
        VERDICT_MALFORMED = 3'd3,
        VERDICT_FULL      = 3'd4
    } t_verdict;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_SCAN   = 2'd1;
    localparam logic [1:0] ACT_FILTER = 2'd2;

    // configuration register map, 4 bytes apart
    localparam int CFG_ADDR_W = 4;
    localparam logic [1:0] REG_SIZE_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_WRITE_TEX_ID   = 2'd1;
    localparam logic [1:0] REG_WRITE_TEX_XL   = 2'd2;
    localparam logic [1:0] REG_CREATE_VIEW_ID = 2'd3;

    localparam logic [31:0] RST_SIZE_THRESHOLD = 32'd4096;
    localparam logic [31:0] RST_WRITE_TEX_ID   = 32'd86;
    localparam logic [31:0] RST_WRITE_TEX_XL   = 32'd87;
    localparam logic [31:0] RST_CREATE_VIEW_ID = 32'd143;

    // minimum sizes in bytes
    localparam logic [63:0] MIN_CMD_BYTES   = 64'd12;
    localparam logic [63:0] MIN_WRITE_BYTES = 64'd32;
    localparam logic [63:0] MIN_XL_BYTES    = 64'd48;
    localparam logic [63:0] MIN_DEFER_BYTES = 64'd24;
    localparam logic [63:0] MIN_VIEW_BYTES  = 64'd72;

endpackage

// ----- sv/tuf_chan_if.sv -----
// valid/ready channel carrying one payload per transaction
// payload type is a parameter, no package dependency
interface tuf_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/tuf_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module tuf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/texture_upload_command_filter.sv -----
// texture upload command filter: a command that needs no table search (clear, malformed,
// pass-through) goes from the check state straight to the done state and into the output
// register; a search walks the filled entries through one ram read port, one entry per cycle,
// and ends on a hit or past the last filled entry, then passes through the update state;
// a new command is taken once the previous result is registered; a stalled result holds off the input
// synchronous active-low reset: table empty (fill count zero), registers at defaults
module texture_upload_command_filter #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tuf_chan_if.sink                        i_cmd,
    tuf_chan_if.source                      o_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tuf_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import tuf_pkg::*;

    `include "texture_upload_command_filter_macros.svh"

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_UPDATE,
        S_DONE
    } t_state;

    // sequencer and command
    t_state        r_state;
    t_cmd          r_cmd;

    // configuration registers
    logic [31:0]   r_size_threshold;
    logic [31:0]   r_write_tex_id;
    logic [31:0]   r_write_tex_xl;
    logic [31:0]   r_create_view_id;

    // table bookkeeping: entries are allocated in order, so valid ones form a prefix
    logic [CW-1:0] r_fill;
    logic [CW-1:0] r_idx;
    logic          r_pend;
    logic [AW-1:0] r_pend_idx;
    logic          r_hit;
    logic [AW-1:0] r_hit_idx;
    logic [31:0]   r_hit_mip;
    logic [31:0]   r_key;
    logic [31:0]   r_mip;
    logic          r_is_scan;

    // result under construction and output register
    t_res          r_res;
    t_res          r_out;
    logic          r_out_valid;

    // decode of the held command
    logic          malformed;
    logic          is_xl;
    logic          is_write;
    logic          is_large;
    logic [31:0]   sel_tex;
    logic [31:0]   sel_mip;
    logic          scan_record;
    logic          filter_defer;
    logic          filter_view;

    // outcome of the check state and of the update state
    t_res          check_res;
    t_state        check_state;
    logic [31:0]   check_key;
    t_res          update_res;

    // ram signals
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_entry        rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    logic          hit_now;
    logic          mip_grows;
    logic          cfg_write;

    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb begin
        case (paddr[CFG_ADDR_W-1:2])
            REG_SIZE_THRESHOLD: prdata = r_size_threshold;
            REG_WRITE_TEX_ID:   prdata = r_write_tex_id;
            REG_WRITE_TEX_XL:   prdata = r_write_tex_xl;
            REG_CREATE_VIEW_ID: prdata = r_create_view_id;
            default:            prdata = '0;
        endcase
    end

    // header checks and command class, evaluated in the check state
    assign malformed = ({32'd0, r_cmd.bytes_left} < MIN_CMD_BYTES)
                    || (r_cmd.command_size < MIN_CMD_BYTES)
                    || (r_cmd.command_size > {32'd0, r_cmd.bytes_left});
    assign is_xl     = (r_cmd.command_number == r_write_tex_xl);
    assign is_write  = (r_cmd.command_number == r_write_tex_id) || is_xl;
    assign is_large  = r_cmd.dword_at_16 > {32'd0, r_size_threshold};
    assign sel_tex   = is_xl ? r_cmd.word_at_40 : r_cmd.word_at_24;
    assign sel_mip   = is_xl ? r_cmd.word_at_44 : r_cmd.word_at_28;

    assign scan_record  = is_write && is_large
                       && (r_cmd.command_size >= (is_xl ? MIN_XL_BYTES : MIN_WRITE_BYTES));
    assign filter_defer = is_write && is_large && (r_cmd.command_size >= MIN_DEFER_BYTES);
    // a descriptor is present when the low word at 16 is nonzero
    assign filter_view  = (r_cmd.command_number == r_create_view_id)
                       && (r_cmd.command_size >= MIN_VIEW_BYTES)
                       && (r_cmd.dword_at_16[31:0] != 32'd0);

    // check state: verdict without the table, and whether a search follows
    always_comb begin
        check_res   = '0;
        check_state = S_DONE;
        check_key   = sel_tex;
        if (r_cmd.action == ACT_SCAN || r_cmd.action == ACT_FILTER) begin
            if (malformed) begin
                check_res.verdict = VERDICT_MALFORMED;
            end else begin
                check_res.advance_bytes = r_cmd.command_size;
                if (r_cmd.action == ACT_SCAN) begin
                    if (scan_record) begin
                        check_state = S_SEARCH;
                    end
                end else if (filter_defer) begin
                    // deferral wins over a clashing view number
                    check_res.verdict          = VERDICT_DEFERRED;
                    check_res.deferred_texture = sel_tex;
                    check_res.deferred_mip     = sel_mip;
                end else if (filter_view) begin
                    check_key   = r_cmd.word_at_12;
                    check_state = S_SEARCH;
                end
            end
        end
    end

    // update state: table full flag, or the view rewrite
    always_comb begin
        update_res = r_res;
        if (r_is_scan) begin
            if (!r_hit && (r_fill == FULL_COUNT)) begin
                update_res.verdict = VERDICT_FULL;
            end
        end else if (r_hit) begin
            // base from the table, count never below one
            update_res.verdict       = VERDICT_REWRITTEN;
            update_res.new_base_mip  = r_hit_mip;
            update_res.new_mip_count = (r_cmd.word_at_68 > r_hit_mip)
                                     ? (r_cmd.word_at_68 - r_hit_mip) : 32'd1;
        end
    end

    // table walk: one read issued per cycle, its data compared in the cycle after
    assign rd_en   = (r_state == S_SEARCH) && (r_idx < r_fill);
    assign rd_addr = r_idx[AW-1:0];
    assign hit_now = r_pend && (rd_data.texture == r_key);

    // scan update: raise the stored mip of a hit, or allocate the next free slot
    assign mip_grows = r_mip > r_hit_mip;
    assign wr_en     = (r_state == S_UPDATE) && r_is_scan
                    && (r_hit ? mip_grows : (r_fill != FULL_COUNT));
    assign wr_addr   = r_hit ? r_hit_idx : r_fill[AW-1:0];
    assign wr_data   = '{texture: r_key, first_mip: r_mip};

    tuf_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign i_cmd.ready   = (r_state == S_IDLE);
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_fill           <= '0;
            r_idx            <= '0;
            r_pend           <= 1'b0;
            r_hit            <= 1'b0;
            r_out_valid      <= 1'b0;
            r_size_threshold <= RST_SIZE_THRESHOLD;
            r_write_tex_id   <= RST_WRITE_TEX_ID;
            r_write_tex_xl   <= RST_WRITE_TEX_XL;
            r_create_view_id <= RST_CREATE_VIEW_ID;
        end else begin
            if (cfg_write) begin
                case (paddr[CFG_ADDR_W-1:2])
                    REG_SIZE_THRESHOLD: r_size_threshold <= pwdata;
                    REG_WRITE_TEX_ID:   r_write_tex_id   <= pwdata;
                    REG_WRITE_TEX_XL:   r_write_tex_xl   <= pwdata;
                    REG_CREATE_VIEW_ID: r_create_view_id <= pwdata;
                    default: ;
                endcase
            end

            // output register loaded from the done state, freed when taken downstream
            if ((r_state == S_DONE) && (!r_out_valid || o_res.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd   <= i_cmd.payload;
                        r_state <= S_CHECK;
                    end
                end

                S_CHECK: begin
                    r_res     <= check_res;
                    r_idx     <= '0;
                    r_pend    <= 1'b0;
                    r_hit     <= 1'b0;
                    r_key     <= check_key;
                    r_mip     <= sel_mip + 32'd1;   // wraps within 32 bits
                    r_is_scan <= (r_cmd.action == ACT_SCAN);
                    r_state   <= check_state;
                    if (r_cmd.action == ACT_CLEAR) begin
                        r_fill <= '0;
                    end
                end

                S_SEARCH: begin
                    r_pend     <= rd_en;
                    r_pend_idx <= rd_addr;
                    r_idx      <= r_idx + CW'(rd_en);
                    if (hit_now) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_pend_idx;
                        r_hit_mip <= rd_data.first_mip;
                        r_state   <= S_UPDATE;
                    end else if (!rd_en && !r_pend) begin
                        // walked past the last filled entry
                        r_state <= S_UPDATE;
                    end
                end

                S_UPDATE: begin
                    r_state <= S_DONE;
                    r_res   <= update_res;
                    if (r_is_scan && !r_hit && (r_fill != FULL_COUNT)) begin
                        r_fill <= r_fill + CW'(1);
                    end
                end

                S_DONE: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // a clear transaction leaves the table empty by the check state's end
    `TUF_ASSERT_NEXT(a_clear_empties,
        (r_state == S_CHECK) && (r_cmd.action == ACT_CLEAR), r_fill == '0,
        "clear did not empty the table")
    // the fill count never passes the table size
    `TUF_ASSERT_NOW(a_fill_bound, r_state != S_IDLE, r_fill <= FULL_COUNT,
        "table fill count overflow")
    // a malformed command never advances the host
    `TUF_ASSERT_NOW(a_malformed_no_adv,
        o_res.valid && (o_res.payload.verdict == VERDICT_MALFORMED),
        o_res.payload.advance_bytes == '0, "malformed command with nonzero advance")
    // a table write only happens on a scan update
    `TUF_ASSERT_NOW(a_write_on_scan, wr_en, (r_state == S_UPDATE) && r_is_scan,
        "table written outside a scan update")

endmodule

// ----- tb/tb_texture_upload_command_filter.sv -----
// testbench for the texture upload command filter: checks every result against a behavioral
// predictor of the filter, under random idling and register settings
// depends on tuf_pkg, tuf_chan_if and texture_upload_command_filter
module tb_texture_upload_command_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import tuf_pkg::*;

    localparam int TABLE_ENTRIES   = 16;
    localparam int ITEMS_PER_PHASE = 280;
    localparam int PHASES          = 5;
    // longest quiet stretch of a correct run is the receiver hold-off plus a few stalls
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int MAX_REPORTS     = 100;
    // action code with no meaning, the block ignores it
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // configuration port, idle from the start
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    tuf_chan_if #(.t_payload(t_cmd)) cmd_if ();
    tuf_chan_if #(.t_payload(t_res)) res_if ();

    texture_upload_command_filter #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_res  (res_if),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // 4 ns period, high then low
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor copy of the registers and of the texture table
    logic [31:0] cfg_threshold = RST_SIZE_THRESHOLD;
    logic [31:0] cfg_write_id  = RST_WRITE_TEX_ID;
    logic [31:0] cfg_xl_id     = RST_WRITE_TEX_XL;
    logic [31:0] cfg_view_id   = RST_CREATE_VIEW_ID;
    bit          tbl_valid     [TABLE_ENTRIES] = '{default: 1'b0};
    logic [31:0] tbl_texture   [TABLE_ENTRIES];
    logic [31:0] tbl_first_mip [TABLE_ENTRIES];

    // commands waiting for the driver, and results the block still owes
    t_cmd pending_commands[$];
    t_res expected_results[$];
    t_res expected_now;

    int  fail_count = 0;
    int  queued_items = 0;
    int  quiet_cycles = 0;
    bit  cmd_fire = 1'b0;
    bit  res_fire = 1'b0;
    int  cmd_wait = 0;
    int  res_wait = 0;
    int  cmd_burst = 0;
    int  res_burst = 0;
    int  hold_requests = 0;
    int  holds_served = 0;
    int  hold_left = 0;

    // interesting command sizes around the thresholds of the filter
    logic [63:0] size_marks [10] = '{11, 12, 23, 24, 31, 32, 47, 48, 71, 72};

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    endtask

    // index of the valid entry holding a texture, -1 when untracked
    function automatic int find_texture(input logic [31:0] tex);
        int i;
        for (i = 0; i < TABLE_ENTRIES; i++)
            if (tbl_valid[i] && tbl_texture[i] == tex)
                return i;
        return -1;
    endfunction

    // verdict and rewrite fields for one accepted command, updates the table copy
    function automatic t_res filter_command(input t_cmd c);
        t_res        r;
        logic        is_xl;
        logic        is_write;
        logic        is_large;
        logic [31:0] tex;
        logic [31:0] mip;
        logic [31:0] next_mip;
        logic [31:0] base;
        int          slot;
        int          i;
        r = '0;
        r.verdict = VERDICT_FORWARD;
        if (c.action == ACT_CLEAR) begin
            for (i = 0; i < TABLE_ENTRIES; i++)
                tbl_valid[i] = 1'b0;
        end else if (c.action == ACT_SCAN || c.action == ACT_FILTER) begin
            if ({32'd0, c.bytes_left} < MIN_CMD_BYTES || c.command_size < MIN_CMD_BYTES
                    || c.command_size > {32'd0, c.bytes_left}) begin
                r.verdict = VERDICT_MALFORMED;
            end else begin
                r.advance_bytes = c.command_size;
                is_xl = (c.command_number == cfg_xl_id);
                is_write = (c.command_number == cfg_write_id) || is_xl;
                tex = is_xl ? c.word_at_40 : c.word_at_24;
                mip = is_xl ? c.word_at_44 : c.word_at_28;
                is_large = c.dword_at_16 > {32'd0, cfg_threshold};
                if (c.action == ACT_SCAN) begin
                    if (is_write && is_large
                            && c.command_size >= (is_xl ? MIN_XL_BYTES : MIN_WRITE_BYTES)) begin
                        next_mip = mip + 32'd1;
                        slot = find_texture(tex);
                        if (slot >= 0) begin
                            if (next_mip > tbl_first_mip[slot])
                                tbl_first_mip[slot] = next_mip;
                        end else begin
                            for (i = 0; i < TABLE_ENTRIES && slot < 0; i++)
                                if (!tbl_valid[i])
                                    slot = i;
                            if (slot >= 0) begin
                                tbl_valid[slot] = 1'b1;
                                tbl_texture[slot] = tex;
                                tbl_first_mip[slot] = next_mip;
                            end else begin
                                r.verdict = VERDICT_FULL;
                            end
                        end
                    end
                end else if (is_write && is_large && c.command_size >= MIN_DEFER_BYTES) begin
                    // deferral wins over a view rewrite when the numbers clash
                    r.verdict = VERDICT_DEFERRED;
                    r.deferred_texture = tex;
                    r.deferred_mip = mip;
                end else if (c.command_number == cfg_view_id && c.command_size >= MIN_VIEW_BYTES
                        && c.dword_at_16[31:0] != 32'd0) begin
                    slot = find_texture(c.word_at_12);
                    if (slot >= 0) begin
                        base = tbl_first_mip[slot];
                        r.verdict = VERDICT_REWRITTEN;
                        r.new_base_mip = base;
                        r.new_mip_count = (c.word_at_68 > base) ? c.word_at_68 - base : 32'd1;
                    end
                end
            end
        end
        return r;
    endfunction

    // every bit of every field at random, any action
    function automatic t_cmd raw_command();
        logic [447:0] bits;
        int           i;
        bits = '0;
        for (i = 0; i < 14; i++)
            bits = {bits[415:0], 32'($urandom)};
        return t_cmd'(bits[$bits(t_cmd)-1:0]);
    endfunction

    // a plausible command: texture write, extended write, view creation or other,
    // textures drawn from a small pool so that views meet tracked textures
    function automatic t_cmd random_command(input logic [31:0] tex_base,
                                            input int unsigned tex_span);
        t_cmd        c;
        logic [31:0] tex;
        logic [31:0] mip;
        logic [63:0] size;
        c = raw_command();
        c.action = ACT_SCAN;
        tex = ($urandom_range(0, 19) == 0) ? $urandom : tex_base + $urandom_range(0, tex_span - 1);
        mip = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 12);
        if ($urandom_range(0, 15) == 0)
            mip = 32'hFFFF_FFFF;
        case ($urandom_range(0, 4))
            0: c.dword_at_16 = {32'd0, cfg_threshold};
            1: c.dword_at_16 = {32'd0, cfg_threshold} + 64'd1;
            2, 3: c.dword_at_16 = {32'd0, cfg_threshold} + 64'($urandom_range(1, 100000));
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                c.command_number = cfg_write_id;
                c.word_at_24 = tex;
                c.word_at_28 = mip;
            end
            3, 4: begin
                c.command_number = cfg_xl_id;
                c.word_at_40 = tex;
                c.word_at_44 = mip;
            end
            5, 6, 7: begin
                c.command_number = cfg_view_id;
                c.word_at_12 = tex;
                c.word_at_68 = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 16);
                // mostly with a descriptor, now and then a flag of zero under set high bits
                if ($urandom_range(0, 5) == 0)
                    c.dword_at_16 = {32'($urandom), 32'd0};
                else
                    c.dword_at_16[31:0] = $urandom_range(1, 3);
            end
            default: ;
        endcase
        case ($urandom_range(0, 7))
            0: size = size_marks[$urandom_range(0, 9)];
            6: size = 64'($urandom_range(72, 4096));
            7: size = {32'($urandom), 32'($urandom)};
            default: size = 64'($urandom_range(12, 300));
        endcase
        c.command_size = size;
        case ($urandom_range(0, 11))
            0: c.bytes_left = $urandom_range(0, 15);
            1: c.bytes_left = size[31:0] - 32'd1;
            2: c.bytes_left = size[31:0];
            3: c.bytes_left = 32'hFFFF_FFFF;
            default: c.bytes_left = size[31:0] + $urandom_range(0, 1024);
        endcase
        return c;
    endfunction

    task automatic queue_command(input t_cmd c);
        pending_commands = {pending_commands, c};
        queued_items++;
    endtask

    // one buffer as the host sends it: optional clear, scan pass, filter pass
    task automatic queue_frame();
        t_cmd        frame[$];
        t_cmd        c;
        logic [31:0] tex_base;
        int unsigned tex_span;
        int unsigned n;
        int unsigned i;
        bit          skip_scan;
        bit          skip_filter;
        n = $urandom_range(2, 24);
        tex_span = $urandom_range(1, 24);
        tex_base = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
        for (i = 0; i < n; i++)
            frame = {frame, random_command(tex_base, tex_span)};
        // leaving the table uncleared lets it fill up across buffers
        if ($urandom_range(0, 2) != 0) begin
            c = raw_command();
            c.action = ACT_CLEAR;
            queue_command(c);
        end
        skip_scan = ($urandom_range(0, 9) == 0);
        skip_filter = !skip_scan && ($urandom_range(0, 9) == 0);
        if (!skip_scan)
            foreach (frame[k]) begin
                c = frame[k];
                c.action = ACT_SCAN;
                queue_command(($urandom_range(0, 11) == 0) ? raw_command() : c);
            end
        if (!skip_filter)
            foreach (frame[k]) begin
                c = frame[k];
                c.action = ACT_FILTER;
                queue_command(($urandom_range(0, 11) == 0) ? raw_command() : c);
            end
    endtask

    // directed command: texture goes to every texture word, mip to both mip words
    task automatic queue_directed(input logic [1:0] act, input logic [31:0] number,
                                  input logic [63:0] size, input logic [31:0] left,
                                  input logic [63:0] data_size, input logic [31:0] tex,
                                  input logic [31:0] mip, input logic [31:0] mip_count);
        t_cmd c;
        c = raw_command();
        c.action = act;
        c.command_number = number;
        c.command_size = size;
        c.bytes_left = left;
        c.dword_at_16 = data_size;
        c.word_at_12 = tex;
        c.word_at_24 = tex;
        c.word_at_40 = tex;
        c.word_at_28 = mip;
        c.word_at_44 = mip;
        c.word_at_68 = mip_count;
        queue_command(c);
    endtask

    // register write with a read back, setup then access phase each
    task automatic program_register(input logic [1:0] index, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (index)
            REG_SIZE_THRESHOLD: cfg_threshold = value;
            REG_WRITE_TEX_ID:   cfg_write_id = value;
            REG_WRITE_TEX_XL:   cfg_xl_id = value;
            REG_CREATE_VIEW_ID: cfg_view_id = value;
            default: ;
        endcase
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== value)
            report_mismatch("register readback", {32'd0, prdata}, {32'd0, value});
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // block idle: nothing queued, nothing offered, nothing owed
    task automatic wait_until_drained();
        do @(posedge i_clk);
        while (pending_commands.size() != 0 || cmd_if.valid || expected_results.size() != 0);
    endtask

    // random per-transaction wait, with stretches of back-to-back traffic
    function automatic int draw_wait(ref int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            burst_left = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    // command driver: changes on the falling edge, holds an offered command until taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (cmd_if.valid && !cmd_fire) begin
            // still offered, keep payload steady
        end else begin
            if (cmd_fire)
                cmd_wait = draw_wait(cmd_burst);
            if (cmd_wait > 0) begin
                cmd_wait = cmd_wait - 1;
                cmd_if.valid <= 1'b0;
            end else if (pending_commands.size() != 0) begin
                cmd_if.payload <= pending_commands.pop_front();
                cmd_if.valid <= 1'b1;
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // result receiver: stalls at random after each transaction, and fully during a hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_fire)
                res_wait = draw_wait(res_burst);
            if (hold_left != 0) begin
                res_if.ready <= 1'b0;
            end else if (res_wait > 0) begin
                res_wait = res_wait - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // long receiver hold-off, counted here so the sender keeps offering meanwhile
    always @(posedge i_clk) begin
        if (hold_requests != holds_served) begin
            hold_left <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: predicts on command transactions, checks result transactions in order,
    // and ends the run when nothing moves for too long
    always @(posedge i_clk) begin
        cmd_fire <= i_rst_n && cmd_if.valid && cmd_if.ready;
        res_fire <= i_rst_n && res_if.valid && res_if.ready;
        if (i_rst_n) begin
            if (cmd_if.valid && cmd_if.ready)
                expected_results = {expected_results, filter_command(cmd_if.payload)};
            if (res_if.valid && res_if.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected",
                                    res_if.payload.advance_bytes, '0);
                end else begin
                    expected_now = expected_results.pop_front();
                    if (res_if.payload.verdict !== expected_now.verdict)
                        report_mismatch("verdict", 64'(res_if.payload.verdict),
                                        64'(expected_now.verdict));
                    if (res_if.payload.new_base_mip !== expected_now.new_base_mip)
                        report_mismatch("new_base_mip", 64'(res_if.payload.new_base_mip),
                                        64'(expected_now.new_base_mip));
                    if (res_if.payload.new_mip_count !== expected_now.new_mip_count)
                        report_mismatch("new_mip_count", 64'(res_if.payload.new_mip_count),
                                        64'(expected_now.new_mip_count));
                    if (res_if.payload.deferred_texture !== expected_now.deferred_texture)
                        report_mismatch("deferred_texture",
                                        64'(res_if.payload.deferred_texture),
                                        64'(expected_now.deferred_texture));
                    if (res_if.payload.deferred_mip !== expected_now.deferred_mip)
                        report_mismatch("deferred_mip", 64'(res_if.payload.deferred_mip),
                                        64'(expected_now.deferred_mip));
                    if (res_if.payload.advance_bytes !== expected_now.advance_bytes)
                        report_mismatch("advance_bytes", res_if.payload.advance_bytes,
                                        expected_now.advance_bytes);
                end
            end
        end
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int phase;
        int i;
        cmd_if.valid = 1'b0;
        cmd_if.payload = '0;
        res_if.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                wait_until_drained();
                case (phase)
                    1: begin
                        // every write with a nonzero data size large, ids at both ends of the range
                        program_register(REG_SIZE_THRESHOLD, 32'd0);
                        program_register(REG_WRITE_TEX_ID, 32'd0);
                        program_register(REG_WRITE_TEX_XL, 32'hFFFF_FFFF);
                        program_register(REG_CREATE_VIEW_ID, RST_CREATE_VIEW_ID);
                    end
                    2: begin
                        // only data sizes past 32 bits are large, extended write clashes with view
                        program_register(REG_SIZE_THRESHOLD, 32'hFFFF_FFFF);
                        program_register(REG_WRITE_TEX_ID, 32'd5);
                        program_register(REG_WRITE_TEX_XL, 32'd143);
                        program_register(REG_CREATE_VIEW_ID, 32'd143);
                    end
                    3: begin
                        // all three command numbers equal
                        program_register(REG_SIZE_THRESHOLD, $urandom_range(1, 5000));
                        program_register(REG_WRITE_TEX_ID, 32'h0000_1234);
                        program_register(REG_WRITE_TEX_XL, 32'h0000_1234);
                        program_register(REG_CREATE_VIEW_ID, 32'h0000_1234);
                    end
                    default: begin
                        program_register(REG_SIZE_THRESHOLD, RST_SIZE_THRESHOLD);
                        program_register(REG_WRITE_TEX_ID, RST_WRITE_TEX_ID);
                        program_register(REG_WRITE_TEX_XL, RST_WRITE_TEX_XL);
                        program_register(REG_CREATE_VIEW_ID, RST_CREATE_VIEW_ID);
                    end
                endcase
            end else begin
                // directed commands under the reset settings
                queue_directed(ACT_CLEAR, $urandom, 64'($urandom), $urandom, '1, 0, 0, 0);
                queue_directed(ACT_UNUSED, RST_WRITE_TEX_ID, 64'd64, 32'd64, '1, 5, 3, 0);
                // short buffer, size below the header, size past the buffer, huge size
                queue_directed(ACT_SCAN, RST_WRITE_TEX_ID, 64'd12, 32'd11, '1, 5, 3, 0);
                queue_directed(ACT_FILTER, RST_WRITE_TEX_ID, 64'd11, 32'd100, '1, 5, 3, 0);
                queue_directed(ACT_SCAN, RST_WRITE_TEX_ID, 64'd101, 32'd100, '1, 5, 3, 0);
                queue_directed(ACT_SCAN, RST_WRITE_TEX_ID, 64'hFFFF_FFFF_0000_0010,
                               32'hFFFF_FFFF, '1, 5, 3, 0);
                // recorded write, then one too short to reach its mip word
                queue_directed(ACT_SCAN, RST_WRITE_TEX_ID, 64'd32, 32'd32, 64'd4097, 5, 3, 0);
                queue_directed(ACT_SCAN, RST_WRITE_TEX_ID, 64'd31, 32'd40, '1, 5, 7, 0);
                // extended write whose mip plus one wraps to zero, then a short one
                queue_directed(ACT_SCAN, RST_WRITE_TEX_XL, 64'd48, 32'd48, 64'd4097, 9,
                               32'hFFFF_FFFF, 0);
                queue_directed(ACT_SCAN, RST_WRITE_TEX_XL, 64'd47, 32'd47, '1, 9, 2, 0);
                // data size equal to the threshold is not large
                queue_directed(ACT_SCAN, RST_WRITE_TEX_ID, 64'hFFFF_FFFF, 32'hFFFF_FFFF,
                               64'd4096, 5, 30, 0);
                queue_directed(ACT_SCAN, RST_WRITE_TEX_ID, 64'hFFFF_FFFF, 32'hFFFF_FFFF,
                               '1, 5, 10, 0);
                // filter pass: deferral at the minimum size, not below it
                queue_directed(ACT_FILTER, RST_WRITE_TEX_ID, 64'd24, 32'd24, 64'd4097, 5, 3, 0);
                queue_directed(ACT_FILTER, RST_WRITE_TEX_XL, 64'd23, 32'd30, '1, 5, 3, 0);
                // view rewrites: normal, too short, no descriptor, count floor, wrapped mip, untracked texture
                queue_directed(ACT_FILTER, RST_CREATE_VIEW_ID, 64'd72, 32'd72, 64'd1, 5, 0, 20);
                queue_directed(ACT_FILTER, RST_CREATE_VIEW_ID, 64'd71, 32'd72, 64'd1, 5, 0, 20);
                queue_directed(ACT_FILTER, RST_CREATE_VIEW_ID, 64'd72, 32'd72,
                               64'h1_0000_0000, 5, 0, 20);
                queue_directed(ACT_FILTER, RST_CREATE_VIEW_ID, 64'd80, 32'd90, '1, 5, 0, 11);
                queue_directed(ACT_FILTER, RST_CREATE_VIEW_ID, 64'd72, 32'd72, 64'd1, 9, 0, 0);
                queue_directed(ACT_FILTER, RST_CREATE_VIEW_ID, 64'd72, 32'd72, 64'd1, 77, 0, 9);
                // fill the table, the last new texture finds no free entry
                for (i = 0; i < TABLE_ENTRIES - 1; i++)
                    queue_directed(ACT_SCAN, RST_WRITE_TEX_ID, 64'd32, 32'd32, 64'd5000,
                                   100 + i, i, 0);
                queue_directed(ACT_FILTER, RST_CREATE_VIEW_ID, 64'd72, 32'd72, 64'd1,
                               100 + TABLE_ENTRIES - 2, 0, 40);
                queue_directed(ACT_FILTER, RST_CREATE_VIEW_ID, 64'd72, 32'd72, 64'd1,
                               100 + TABLE_ENTRIES - 1, 0, 40);
                // after a clear nothing is tracked
                queue_directed(ACT_CLEAR, 0, 64'd0, 0, 64'd0, 0, 0, 0);
                queue_directed(ACT_FILTER, RST_CREATE_VIEW_ID, 64'd72, 32'd72, 64'd1, 5, 0, 20);
            end

            // receiver hold-off while the sender keeps going, so the input backs up
            if (phase == 1 || phase == 3)
                hold_requests++;
            queued_items = 0;
            while (queued_items < ITEMS_PER_PHASE)
                queue_frame();
        end

        wait_until_drained();
        // a stray result would still show up within one table search
        repeat (TABLE_ENTRIES + 10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/tuf_pkg.sv
sv/tuf_chan_if.sv
sv/tuf_ram.sv
sv/texture_upload_command_filter.sv
tb/tb_texture_upload_command_filter.sv
